>>> rtl/mlp_forward_inference_macros.svh
// assertion macros for the forward inference block
`ifndef MLP_FORWARD_INFERENCE_MACROS_SVH
`define MLP_FORWARD_INFERENCE_MACROS_SVH
`ifndef SYNTH
`define MLP_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define MLP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define MLP_ASSERT_SAME(lbl, ante, cons)
`define MLP_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

>>> rtl/mlp_pkg.sv
`default_nettype none
package mlp_pkg;
  localparam int MAX_LAYERS = 5;
  localparam int MAX_WIDTH = 128;
  localparam int RESULT_LIMIT = 64;
  localparam int DIV_BITS = 30;

  localparam logic [1:0] CMD_WEIGHT = 2'd0;
  localparam logic [1:0] CMD_BIAS = 2'd1;
  localparam logic [1:0] CMD_SAMPLE = 2'd2;

  localparam logic [2:0] REG_LAYERS = 3'd0;
  localparam logic [2:0] REG_W0 = 3'd1;
  localparam logic [2:0] REG_W1 = 3'd2;
  localparam logic [2:0] REG_W2 = 3'd3;
  localparam logic [2:0] REG_W3 = 3'd4;
  localparam logic [2:0] REG_W4 = 3'd5;
  localparam logic [2:0] REG_ACT = 3'd6;

  localparam logic [2:0] ACT_RELU = 3'd0;
  localparam logic [2:0] ACT_TANH = 3'd1;
  localparam logic [2:0] ACT_SIGMOID = 3'd2;
  localparam logic [2:0] ACT_ELU = 3'd3;
  localparam logic [2:0] ACT_IDENTITY = 3'd4;

  typedef struct packed {
    logic [1:0] command;
    logic [1:0] stage;
    logic [6:0] src_index;
    logic [6:0] dst_index;
    logic signed [15:0] value;
    logic end_of_vector;
  } item_t;

  typedef struct packed {
    logic [6:0] out_index;
    logic signed [15:0] out_value;
    logic last;
  } result_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_BIAS, ST_MAC, ST_ROUND, ST_EXP, ST_PREP, ST_DIV, ST_WB,
    ST_ORD, ST_OWAIT, ST_OHOLD
  } state_t;

  // exp(-k/4) in Q1.16
  function automatic logic [16:0] exp_tab(input logic [5:0] k);
    case (k)
      6'd0: exp_tab = 17'd65536;  6'd1: exp_tab = 17'd51039;
      6'd2: exp_tab = 17'd39749;  6'd3: exp_tab = 17'd30957;
      6'd4: exp_tab = 17'd24109;  6'd5: exp_tab = 17'd18776;
      6'd6: exp_tab = 17'd14623;  6'd7: exp_tab = 17'd11388;
      6'd8: exp_tab = 17'd8869;   6'd9: exp_tab = 17'd6907;
      6'd10: exp_tab = 17'd5380;  6'd11: exp_tab = 17'd4190;
      6'd12: exp_tab = 17'd3263;  6'd13: exp_tab = 17'd2541;
      6'd14: exp_tab = 17'd1979;  6'd15: exp_tab = 17'd1541;
      6'd16: exp_tab = 17'd1200;  6'd17: exp_tab = 17'd935;
      6'd18: exp_tab = 17'd728;   6'd19: exp_tab = 17'd567;
      6'd20: exp_tab = 17'd442;   6'd21: exp_tab = 17'd344;
      6'd22: exp_tab = 17'd268;   6'd23: exp_tab = 17'd209;
      6'd24: exp_tab = 17'd162;   6'd25: exp_tab = 17'd127;
      6'd26: exp_tab = 17'd99;    6'd27: exp_tab = 17'd77;
      6'd28: exp_tab = 17'd60;    6'd29: exp_tab = 17'd47;
      6'd30: exp_tab = 17'd36;    6'd31: exp_tab = 17'd28;
      default: exp_tab = 17'd22;
    endcase
  endfunction

  // exp(-t), t in Q5.12, linear interpolation
  function automatic logic [16:0] exp_neg(input logic [16:0] t);
    logic [6:0] k;
    logic [9:0] f;
    logic [16:0] hi;
    logic [16:0] diff;
    logic [26:0] prod;
    k = t[16:10];
    f = t[9:0];
    hi = exp_tab(k[5:0]);
    diff = hi - exp_tab(k[5:0] + 6'd1);
    prod = diff * f;
    if (k >= 7'd32) exp_neg = 17'd22;
    else exp_neg = hi - prod[26:10];
  endfunction

  function automatic logic [7:0] clamp_width(input logic [7:0] w);
    if (w == 8'd0) clamp_width = 8'd1;
    else if (w > 8'(MAX_WIDTH)) clamp_width = 8'(MAX_WIDTH);
    else clamp_width = w;
  endfunction
endpackage
`default_nettype wire

>>> rtl/mlp_forward_inference.sv
`default_nettype none
// Fully connected network inference, Q4.12. Weight and bias loads and sample
// elements are taken one per cycle while the block is idle. The sample element
// marked end_of_vector starts a pass that holds stall high: every neuron goes
// through bias fetch, the multiply-accumulate stream through the weight memory
// read port with its drain, rounding, exp lookup, setup and write-back, plus
// the radix-2 divider when the activation is tanh or sigmoid. The output layer
// (first 64 neurons at most) is then sent one result at a time, each held
// while result_stall is high, then the block returns to taking requests.
// No clearing pass after reset.
`include "mlp_forward_inference_macros.svh"
module mlp_forward_inference import mlp_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire item_t item,
  input  wire logic item_valid,
  output logic item_stall,
  output result_t result,
  output logic result_valid,
  input  wire logic result_stall,
  input  wire logic cfg_valid,
  output logic cfg_ready,
  input  wire logic [2:0] cfg_index,
  input  wire logic [7:0] cfg_data
);
  logic [2:0] layer_count;
  logic [7:0] widths [5];
  logic [2:0] act_mode;

  logic signed [15:0] wmem [(MAX_LAYERS-1)*MAX_WIDTH*MAX_WIDTH];
  logic signed [15:0] bmem [(MAX_LAYERS-1)*MAX_WIDTH];
  logic signed [15:0] amem [2*MAX_WIDTH];
  logic signed [15:0] w_q, b_q, a_q;
  logic [15:0] w_raddr;
  logic [8:0] b_raddr;
  logic [7:0] a_raddr, a_waddr;
  logic signed [15:0] a_wdata;
  logic a_we;

  state_t state, state_next;
  logic [1:0] s;
  logic cur;
  logic [7:0] j, k;
  logic rd_v, prod_v, first;
  logic signed [31:0] prod, acc;
  logic signed [15:0] x, res;
  logic [16:0] e;
  logic [29:0] dvd;
  logic [17:0] den, rem;
  logic [4:0] dcnt;
  logic neg;
  logic [6:0] ok;

  logic [2:0] n_used;
  logic [7:0] wsrc, wdst;
  logic [6:0] cnt;
  logic [2:0] mode;
  logic accept, mac_done;
  logic [7:0] wfinal;

  assign cfg_ready = 1'b1;
  assign accept = item_valid && !item_stall;
  assign item_stall = (state != ST_IDLE);
  assign result_valid = (state == ST_OHOLD);

  always_comb begin
    if (layer_count < 3'd2) n_used = 3'd2;
    else if (layer_count > 3'(MAX_LAYERS)) n_used = 3'(MAX_LAYERS);
    else n_used = layer_count;
    wsrc = clamp_width(widths[s]);
    wdst = clamp_width(widths[3'(s) + 3'd1]);
    wfinal = clamp_width(widths[n_used - 3'd1]);
    cnt = (wfinal > 8'(RESULT_LIMIT)) ? 7'(RESULT_LIMIT) : wfinal[6:0];
    mode = (act_mode > ACT_IDENTITY) ? ACT_IDENTITY : act_mode;
    mac_done = (k == wsrc) && !rd_v && !prod_v && !first;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      layer_count <= 3'd5;
      widths[0] <= 8'd20;
      widths[1] <= 8'd40;
      widths[2] <= 8'd60;
      widths[3] <= 8'd40;
      widths[4] <= 8'd20;
      act_mode <= ACT_TANH;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_LAYERS: layer_count <= cfg_data[2:0];
        REG_W0: widths[0] <= cfg_data;
        REG_W1: widths[1] <= cfg_data;
        REG_W2: widths[2] <= cfg_data;
        REG_W3: widths[3] <= cfg_data;
        REG_W4: widths[4] <= {1'b0, cfg_data[6:0]};
        REG_ACT: act_mode <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  // memories
  always_comb begin
    w_raddr = {s, k[6:0], j[6:0]};
    b_raddr = {s, j[6:0]};
    a_raddr = (state == ST_MAC) ? {cur, k[6:0]} : {cur, ok};
    a_we = (accept && item.command == CMD_SAMPLE) || (state == ST_WB);
    a_waddr = (state == ST_WB) ? {~cur, j[6:0]} : {1'b0, item.src_index};
    a_wdata = (state == ST_WB) ? res : item.value;
  end

  always_ff @(posedge clk) begin
    if (accept && item.command == CMD_WEIGHT)
      wmem[{item.stage, item.src_index, item.dst_index}] <= item.value;
    w_q <= wmem[w_raddr];
  end

  always_ff @(posedge clk) begin
    if (accept && item.command == CMD_BIAS)
      bmem[{item.stage, item.dst_index}] <= item.value;
    b_q <= bmem[b_raddr];
  end

  always_ff @(posedge clk) begin
    if (a_we) amem[a_waddr] <= a_wdata;
    a_q <= amem[a_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:
        if (accept && item.command == CMD_SAMPLE && item.end_of_vector)
          state_next = ST_BIAS;
      ST_BIAS: state_next = ST_MAC;
      ST_MAC: if (mac_done) state_next = ST_ROUND;
      ST_ROUND: state_next = ST_EXP;
      ST_EXP: state_next = ST_PREP;
      ST_PREP:
        if (mode == ACT_TANH || mode == ACT_SIGMOID) state_next = ST_DIV;
        else state_next = ST_WB;
      ST_DIV: if (dcnt == 5'd0) state_next = ST_WB;
      ST_WB:
        if (j + 8'd1 < wdst) state_next = ST_BIAS;
        else if (3'(s) + 3'd2 < n_used) state_next = ST_BIAS;
        else state_next = ST_ORD;
      ST_ORD: state_next = ST_OWAIT;
      ST_OWAIT: state_next = ST_OHOLD;
      ST_OHOLD:
        if (!result_stall) state_next = result.last ? ST_IDLE : ST_ORD;
      default: state_next = ST_IDLE;
    endcase
  end

  // datapath
  always_ff @(posedge clk) begin
    logic signed [32:0] sum;
    logic signed [32:0] rnd;
    logic signed [20:0] sh;
    logic [15:0] mag;
    logic [16:0] t;
    logic [18:0] rs;
    logic [17:0] dn;
    if (rst) begin
      rd_v <= 1'b0;
      prod_v <= 1'b0;
      first <= 1'b0;
      s <= '0;
      cur <= 1'b0;
      j <= '0;
      k <= '0;
      ok <= '0;
    end else begin
      rd_v <= 1'b0;
      prod_v <= 1'b0;
      case (state)
        ST_IDLE: begin
          s <= '0;
          cur <= 1'b0;
          j <= '0;
          ok <= '0;
        end
        ST_BIAS: begin
          k <= '0;
          first <= 1'b1;
        end
        ST_MAC: begin
          first <= 1'b0;
          if (k < wsrc) begin
            k <= k + 8'd1;
            rd_v <= 1'b1;
          end
          if (rd_v) begin
            prod <= a_q * w_q;
            prod_v <= 1'b1;
          end
          if (first) acc <= 32'(b_q) <<< 12;
          else if (prod_v) begin
            sum = 33'(acc) + 33'(prod);
            if (sum > 33'sh0_7FFF_FFFF) acc <= 32'h7FFF_FFFF;
            else if (sum < -33'sh0_8000_0000) acc <= 32'h8000_0000;
            else acc <= sum[31:0];
          end
        end
        ST_ROUND: begin
          rnd = 33'(acc) + 33'sd2048;
          sh = 21'(rnd >>> 12);
          if (sh > 21'sd32767) x <= 16'sh7FFF;
          else if (sh < -21'sd32768) x <= 16'sh8000;
          else x <= sh[15:0];
        end
        ST_EXP: begin
          mag = x[15] ? 16'(-x) : x;
          t = (mode == ACT_TANH) ? {mag, 1'b0} : {1'b0, mag};
          e <= exp_neg(t);
        end
        ST_PREP: begin
          dn = 18'd65536 + 18'(e);
          den <= dn;
          rem <= '0;
          dcnt <= 5'(DIV_BITS - 1);
          neg <= 1'b0;
          case (mode)
            ACT_RELU: res <= x[15] ? 16'sd0 : x;
            ACT_TANH: begin
              dvd <= 30'((17'd65536 - e) * 30'd4096) + 30'(dn >> 1);
              neg <= x[15];
            end
            ACT_SIGMOID:
              if (!x[15]) dvd <= 30'd268435456 + 30'(dn >> 1);
              else dvd <= 30'(e * 30'd4096) + 30'(dn >> 1);
            ACT_ELU:
              if (!x[15] && x != 16'sd0) res <= x;
              else res <= -16'((18'd65536 - 18'(e) + 18'd8) >> 4);
            default: res <= x;
          endcase
        end
        ST_DIV: begin
          // restoring divide, one quotient bit per cycle
          rs = {rem, dvd[29]};
          if (rs >= {1'b0, den}) begin
            rem <= 18'(rs - {1'b0, den});
            dvd <= {dvd[28:0], 1'b1};
          end else begin
            rem <= rs[17:0];
            dvd <= {dvd[28:0], 1'b0};
          end
          dcnt <= dcnt - 5'd1;
        end
        ST_WB: begin
          if (j + 8'd1 < wdst) j <= j + 8'd1;
          else begin
            j <= '0;
            s <= s + 2'd1;
            cur <= ~cur;
          end
        end
        ST_OWAIT: begin
          result.out_index <= ok;
          result.out_value <= a_q;
          result.last <= (ok + 7'd1 == cnt);
        end
        ST_OHOLD: if (!result_stall) ok <= ok + 7'd1;
        default: ;
      endcase
      if (state == ST_DIV && dcnt == 5'd0) begin
        res <= neg ? -16'({dvd[14:0], (rs >= {1'b0, den})})
                   : 16'({dvd[14:0], (rs >= {1'b0, den})});
      end
    end
  end

  `MLP_ASSERT_SAME(no_input_during_output, result_valid, item_stall)
  `MLP_ASSERT_SAME(product_follows_read, prod_v, $past(rd_v))
  `MLP_ASSERT_NEXT(idle_after_last, result_valid && !result_stall && result.last,
                   !result_valid && !item_stall)
endmodule
`default_nettype wire
